/* rtl/assert_macros.svh */
// Assertion macros used by the CRC16 engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/dmcrc16_pkg.sv */
// Types and constants of the dual-mode CRC16 engine.
package dmcrc16_pkg;

    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_PLAIN  = 2'd1;
    localparam logic [1:0] MODE_MODBUS = 2'd2;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    localparam logic [15:0] PLAIN_POLY  = 16'h00D8;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;
    localparam logic [15:0] MODBUS_INIT = 16'hFFFF;
    localparam logic [15:0] PLAIN_INIT  = 16'h0000;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

/* rtl/dmcrc16_ifs.sv */
// Valid/ready channel interfaces for input items and results.
interface dmcrc16_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface dmcrc16_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink (input valid, input crc_value, output ready);
endinterface

/* rtl/dual_mode_crc16_engine.sv */
// Dual-mode CRC16 engine: byte-wise remainder update, one result per item.
//
// Channels: "item" (sink) carries opcode (begin / add) and data_byte;
// "result" (source) returns crc_value, the remainder after that item.
// Both use valid/ready; a beat moves when valid and ready are high.
// cfg_we/cfg_wdata write the 2-bit mode (hold, plain CRC16, Modbus);
// write it only while no item is in flight.
//
// Path: an accepted beat is held in the input register, then the
// fold logic (eight unrolled shift steps, all XOR) writes the remainder and
// the result register together when the core advances, which raises
// result.valid; the result beat then moves once result.ready is high.
// Throughput: one item per cycle while result.ready stays high; the remainder
// register is the only loop-carried state.
//
// Reset: remainder clears to 0, mode returns to plain CRC16, both stages
// empty. Stall: while result.ready is low the result holds; the input stage
// still takes one more beat, then item.ready drops until the result moves.
`include "assert_macros.svh"

module dual_mode_crc16_engine
    import dmcrc16_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dmcrc16_item_if.sink      item,
    dmcrc16_result_if.source  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata
);

    logic [1:0]  mode_reg;
    logic [15:0] remainder_reg;
    logic [15:0] remainder_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] crc_value_reg;
    stage_t      stage;
    logic        advance;

    // core fires when the input stage holds a beat and the result slot frees
    assign advance = stage.valid && (!out_valid_reg || result.ready);

    dmcrc16_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    dmcrc16_update u_update (
        .remainder      (remainder_reg),
        .item           (stage.item),
        .mode           (mode_reg),
        .remainder_next (remainder_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PLAIN;
            remainder_reg <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (advance)
            begin
                remainder_reg <= remainder_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the same value as the remainder
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            crc_value_reg <= remainder_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.crc_value = crc_value_reg;

    // a waiting result always mirrors the live remainder
    `ASSERT_IMPLY(a_result_matches_rem, clk, rst_n, out_valid_reg,
        crc_value_reg == remainder_reg)
    // full input stage behind a stalled result must backpressure
    `ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n,
        stage.valid && out_valid_reg && !result.ready, !item.ready)
    // Modbus begin loads the all-ones seed
    `ASSERT_NEXT(a_modbus_seed, clk, rst_n,
        advance && stage.item.opcode == OP_BEGIN && mode_reg == MODE_MODBUS,
        remainder_reg == MODBUS_INIT && out_valid_reg)
    // add in hold mode or the unused code leaves the remainder alone
    `ASSERT_NEXT(a_hold_mode, clk, rst_n,
        advance && stage.item.opcode == OP_ADD && mode_reg != MODE_PLAIN
            && mode_reg != MODE_MODBUS,
        $stable(remainder_reg))

endmodule

/* rtl/dmcrc16_in_stage.sv */
// Input register stage: captures one beat, releases it when the core advances.
module dmcrc16_in_stage
    import dmcrc16_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    dmcrc16_item_if.sink        item,
    input  logic                advance,
    output stage_t              stage
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign item.ready = !valid_reg || advance;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode    <= item.opcode;
            item_reg.data_byte <= item.data_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

/* rtl/dmcrc16_update.sv */
// Next-remainder logic: begin load, or one byte folded in eight unrolled shifts.
module dmcrc16_update
    import dmcrc16_pkg::*;
(
    input  logic [15:0] remainder,
    input  item_t       item,
    input  logic [1:0]  mode,
    output logic [15:0] remainder_next
);

    logic [15:0] plain_r;
    logic [15:0] modbus_r;

    // MSB-first, tap 0x00D8 when the bit shifted out was set
    always_comb
    begin
        plain_r = remainder ^ {8'h00, item.data_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (plain_r[15])
            begin
                plain_r = {plain_r[14:0], 1'b0} ^ PLAIN_POLY;
            end
            else
            begin
                plain_r = {plain_r[14:0], 1'b0};
            end
        end
    end

    // reflected, LSB-first with 0xA001
    always_comb
    begin
        modbus_r = remainder ^ {8'h00, item.data_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (modbus_r[0])
            begin
                modbus_r = {1'b0, modbus_r[15:1]} ^ MODBUS_POLY;
            end
            else
            begin
                modbus_r = {1'b0, modbus_r[15:1]};
            end
        end
    end

    always_comb
    begin
        if (item.opcode == OP_BEGIN)
        begin
            remainder_next = (mode == MODE_MODBUS) ? MODBUS_INIT : PLAIN_INIT;
        end
        else
        begin
            case (mode)
                MODE_PLAIN:  remainder_next = plain_r;
                MODE_MODBUS: remainder_next = modbus_r;
                default:     remainder_next = remainder;  // hold mode and unused code
            endcase
        end
    end

endmodule

/* tb/sv/tb_dual_mode_crc16_engine.sv */
// Self-checking testbench for the dual-mode CRC16 engine (plain, Modbus, hold modes).
module tb_dual_mode_crc16_engine;
    import dmcrc16_pkg::*;

    // Mode value 3 has no meaning in the block; it behaves like hold mode
    // except that nothing names it in the package.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Slack allowed after the results are back.
    localparam int SETTLE_CYCLES = 8;
    // Long receiver hold-off, well past the depth of the two pipeline stages.
    localparam int HOLD_CYCLES   = 40;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    dmcrc16_item_if   item_ch ();
    dmcrc16_result_if result_ch ();

    dual_mode_crc16_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the block's state: the mode register and the running remainder.
    logic [1:0]  mode_shadow = MODE_PLAIN;
    logic [15:0] crc_model   = 16'h0000;

    // Remainders still owed by the block, oldest first.
    logic [15:0] crc_expected[$];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  error_count   = 0;

    // Idling knobs: sender gaps, receiver stalls, and the long receiver hold.
    bit  gaps_on       = 1'b1;
    bit  stalls_on     = 1'b1;
    bit  hold_request  = 1'b0;
    logic receiver_held = 1'b0;

    // ------------------------------------------------------------------
    // CRC prediction
    // ------------------------------------------------------------------

    // Plain mode: byte goes into the low bits, then eight left shifts; the
    // polynomial is folded in whenever the bit shifted out of 15 was set.
    function automatic logic [15:0] fold_msb_first(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] crc;
        logic        carry;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            carry = crc[15];
            crc   = {crc[14:0], 1'b0};
            if (carry)
                crc = crc ^ PLAIN_POLY;
        end
        return crc;
    endfunction

    // Modbus mode: reflected update, eight right shifts with 0xA001.
    function automatic logic [15:0] fold_reflected(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] crc;
        logic        carry;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            carry = crc[0];
            crc   = {1'b0, crc[15:1]};
            if (carry)
                crc = crc ^ MODBUS_POLY;
        end
        return crc;
    endfunction

    // Remainder after one beat. Hold mode and the spare value keep the
    // remainder on an add; a begin loads the Modbus seed only in Modbus mode.
    function automatic logic [15:0] crc_after_beat(input logic [1:0]  mode,
                                                   input logic [15:0] crc_in,
                                                   input item_t       beat);
        if (beat.opcode == OP_BEGIN)
            return (mode == MODE_MODBUS) ? MODBUS_INIT : PLAIN_INIT;
        case (mode)
            MODE_PLAIN:  return fold_msb_first(crc_in, beat.data_byte);
            MODE_MODBUS: return fold_reflected(crc_in, beat.data_byte);
            default:     return crc_in;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("tb: mismatch: %s", what);
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The watchdog is set far beyond the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold when requested
    // ------------------------------------------------------------------

    initial
    begin : receiver_hold
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                receiver_held <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                receiver_held <= 1'b0;
            end
        end
    end

    initial
    begin : result_ready_driver
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || receiver_held)
                result_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                // start a stall burst of random length, this cycle included
                stall_left = $urandom_range(1, 7) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Beat monitor: predicts on each input beat, checks each result beat.
    // Both sides live in one process so a push and a pop never race.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : beat_monitor
        logic [15:0] crc_want;
        item_t       beat;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                beat.opcode    = item_ch.opcode;
                beat.data_byte = item_ch.data_byte;
                crc_model      = crc_after_beat(mode_shadow, crc_model, beat);
                crc_expected.push_back(crc_model);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (crc_expected.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected",
                                              result_ch.crc_value));
                else
                begin
                    crc_want = crc_expected.pop_front();
                    if (result_ch.crc_value !== crc_want)
                        report_mismatch($sformatf("crc_value %h, expected %h",
                                                  result_ch.crc_value, crc_want));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks. All are entered just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one beat and hold it until accepted. Valid stays high between
    // back-to-back calls unless a gap burst is drawn.
    task automatic send_item(input logic opcode, input logic [7:0] data_byte);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= opcode;
        item_ch.data_byte <= data_byte;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Sender goes quiet until every owed result is back, then waits SETTLE_CYCLES.
    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        wait (results_seen == items_sent);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mode register write; only called with the pipeline empty.
    task automatic write_mode(input logic [1:0] mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_shadow = mode;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: plain mode, remainder 0, adds with no begin first.
    task automatic test_add_after_reset();
        send_item(OP_ADD, 8'h00);
        send_item(OP_ADD, 8'hFF);
        send_item(OP_ADD, 8'h80);
        wait_for_results();
    endtask

    // Plain CRC16: byte extremes, single bits, and a begin whose data is ignored.
    task automatic test_plain_mode();
        write_mode(MODE_PLAIN);
        send_item(OP_BEGIN, 8'h00);
        send_item(OP_ADD, 8'hFF);
        send_item(OP_ADD, 8'h01);
        send_item(OP_ADD, 8'h80);
        send_item(OP_ADD, 8'hA5);
        send_item(OP_BEGIN, 8'hFF);
        wait_for_results();
    endtask

    // Modbus: seed 0xFFFF, then the classic "123" plus a zero byte.
    task automatic test_modbus_mode();
        write_mode(MODE_MODBUS);
        send_item(OP_BEGIN, 8'h5A);
        send_item(OP_ADD, 8'h31);
        send_item(OP_ADD, 8'h32);
        send_item(OP_ADD, 8'h33);
        send_item(OP_ADD, 8'h00);
        wait_for_results();
    endtask

    // Mode change mid-stream: the remainder carries across into plain mode.
    task automatic test_mode_switch();
        write_mode(MODE_PLAIN);
        send_item(OP_ADD, 8'h7E);
        send_item(OP_ADD, 8'hFF);
        wait_for_results();
    endtask

    // Hold mode and the spare mode value: begin loads 0, adds change nothing.
    task automatic test_hold_modes();
        write_mode(MODE_PLAIN);
        send_item(OP_ADD, 8'hC3);   // nonzero remainder going into hold
        wait_for_results();
        write_mode(MODE_HOLD);
        send_item(OP_ADD, 8'hFF);
        send_item(OP_BEGIN, 8'h12);
        send_item(OP_ADD, 8'h00);
        wait_for_results();
        write_mode(MODE_SPARE);
        send_item(OP_BEGIN, 8'hFF);
        send_item(OP_ADD, 8'hAA);
        wait_for_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills up and drops item ready.
    task automatic test_backpressure();
        write_mode(MODE_MODBUS);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        send_item(OP_BEGIN, 8'h00);
        repeat (24)
            send_item(OP_ADD, 8'($urandom_range(0, 255)));
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    // Frames of a begin and 1..12 adds with random bytes; about one pick in
    // ten is a stray beat of random opcode instead.
    task automatic test_random_frames(input logic [1:0] mode, input int beats);
        int count;
        int frame_len;
        count = 0;
        write_mode(mode);
        while (count < beats)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                count++;
            end
            else
            begin
                frame_len = $urandom_range(1, 12);
                send_item(OP_BEGIN, 8'($urandom_range(0, 255)));
                count++;
                repeat (frame_len)
                begin
                    send_item(OP_ADD, 8'($urandom_range(0, 255)));
                    count++;
                end
            end
        end
        wait_for_results();
    endtask

    // Random part over all mode values; the last two phases run with no idling.
    task automatic test_random_traffic();
        test_random_frames(MODE_MODBUS, 55);
        test_random_frames(MODE_PLAIN, 55);
        test_random_frames(MODE_HOLD, 20);
        test_random_frames(MODE_MODBUS, 45);
        test_random_frames(MODE_SPARE, 20);
        test_random_frames(MODE_PLAIN, 45);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_frames(MODE_MODBUS, 40);
        test_random_frames(MODE_PLAIN, 30);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = MODE_HOLD;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = OP_BEGIN;
        item_ch.data_byte = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_after_reset();
        test_plain_mode();
        test_modbus_mode();
        test_mode_switch();
        test_hold_modes();
        test_backpressure();
        test_random_traffic();

        if (crc_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", crc_expected.size()));
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dmcrc16_pkg.sv
rtl/dmcrc16_ifs.sv
rtl/dmcrc16_in_stage.sv
rtl/dmcrc16_update.sv
rtl/dual_mode_crc16_engine.sv
tb/sv/tb_dual_mode_crc16_engine.sv
